@@ rtl/rdq_pkg.sv @@
// Shared types and constants for the ring deque work queue.
package rdq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ITEM_WIDTH_DEF = 32;

    localparam int FUNC_W = 3;
    localparam int STAT_W = 3;
    localparam int CAP_W  = 5;
    localparam int FILL_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes on func
    localparam logic [FUNC_W-1:0] FN_PUSH_TAIL = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_HEAD = 3'd1;
    localparam logic [FUNC_W-1:0] FN_POP       = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SHUTDOWN  = 3'd4;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_SHUT  = 3'd3,
        ST_NULL  = 3'd4
    } status_t;

endpackage

@@ rtl/rdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ring_deque_work_queue_top.sv @@
// Top level of the ring deque work queue: control, pointers and result register.
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  -------------------------------
//  command   in         start & !busy           func, item_in
//  result    out        done (one-cycle pulse)  status, item_out, fill_level
//  config    in         cfg_valid & cfg_ready   cfg_data (capacity in use)
//
// One command is taken per cycle; its result shows in the next cycle, together
// with the registered read of the slot RAM that a pop needs.
// busy is always low: the state update and the RAM access never stall a command.
// Reset empties the queue, opens it and sets the capacity to 16; slot
// contents are not cleared, an empty queue never reads them.
// done is a single-cycle strobe; the receiver cannot hold results off.
module ring_deque_work_queue_top #(
    parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = rdq_pkg::ITEM_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // command transfer
    input  logic                      start,
    output logic                      busy,
    input  logic [rdq_pkg::FUNC_W-1:0] func,
    input  logic [ITEM_WIDTH-1:0]     item_in,
    // result transfer
    output logic                      done,
    output rdq_pkg::status_t          status,
    output logic [ITEM_WIDTH-1:0]     item_out,
    output logic [rdq_pkg::FILL_W-1:0] fill_level,
    // capacity register write
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rdq_pkg::CAP_W-1:0] cfg_data
);

    import rdq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    // architectural state
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             closed_reg, closed_next;
    logic [CAP_W-1:0] cap_reg;

    // result register
    logic             done_reg;
    status_t          status_reg, status_next;
    logic [FILL_W-1:0] fill_reg;
    logic             pop_ok_reg, pop_ok;

    // slot RAM access
    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [ITEM_WIDTH-1:0] rd_data;

    logic             accept;
    logic [CMP_W-1:0] cap_ext;
    logic [CNT_W-1:0] cap_now;
    logic [CNT_W-1:0] head_ext;
    logic [CNT_W-1:0] tail_ext;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] head_dec;
    logic [PTR_W-1:0] tail_inc;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // capacity clamp: zero acts as one, above DEPTH acts as DEPTH
    assign cap_ext = CMP_W'(cap_reg);
    always_comb
    begin
        priority if (cap_reg == '0)
        begin
            cap_now = CNT_W'(1);
        end
        else if (cap_ext > CMP_W'(DEPTH))
        begin
            cap_now = CNT_W'(DEPTH);
        end
        else
        begin
            cap_now = CNT_W'(cap_reg);
        end
    end

    // pointer wrap at the capacity currently in use
    assign head_ext = CNT_W'(head_reg);
    assign tail_ext = CNT_W'(tail_reg);
    assign head_inc = ((head_ext + CNT_W'(1)) >= cap_now) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc = ((tail_ext + CNT_W'(1)) >= cap_now) ? '0 : tail_reg + PTR_W'(1);
    assign head_dec = (head_reg == '0 || head_ext > cap_now) ?
                      PTR_W'(cap_now - CNT_W'(1)) : head_reg - PTR_W'(1);

    // one operation per accepted command
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        status_next = ST_OK;
        pop_ok      = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        if (accept)
        begin
            unique case (func)
                FN_PUSH_TAIL, FN_PUSH_HEAD:
                begin
                    priority if (closed_reg)
                    begin
                        status_next = ST_SHUT;
                    end
                    else if (count_reg >= cap_now)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (item_in == '0)
                    begin
                        status_next = ST_NULL;
                    end
                    else if (func == FN_PUSH_TAIL)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = tail_reg;
                        tail_next  = tail_inc;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FN_POP:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = closed_reg ? ST_SHUT : ST_EMPTY;
                    end
                    else
                    begin
                        pop_ok     = 1'b1;
                        head_next  = head_inc;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                FN_CLEAR:
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                FN_SHUTDOWN:
                begin
                    closed_next = 1'b1;
                end
                default:
                begin
                    // unused codes: no operation, status ok
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            closed_reg <= 1'b0;
            cap_reg    <= CAP_RESET;
            done_reg   <= 1'b0;
            pop_ok_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
            done_reg   <= accept;
            pop_ok_reg <= pop_ok;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            fill_reg   <= FILL_W'(count_next);
        end
    end

    // head slot read, data lands with the result strobe
    rdq_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_in),
        .rd_en   (pop_ok),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign done       = done_reg;
    assign status     = status_reg;
    assign fill_level = fill_reg;
    assign item_out   = pop_ok_reg ? rd_data : '0;

endmodule

@@ rtl/rdq_checker.sv @@
// Port-level assertions for the ring deque work queue, bound to the top level.
module rdq_checker #(
    parameter int ITEM_WIDTH = rdq_pkg::ITEM_WIDTH_DEF
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [rdq_pkg::FUNC_W-1:0] func,
    input logic [ITEM_WIDTH-1:0]      item_in,
    input logic                       done,
    input rdq_pkg::status_t           status,
    input logic [ITEM_WIDTH-1:0]      item_out,
    input logic [rdq_pkg::FILL_W-1:0] fill_level
);

    import rdq_pkg::*;

    // every accepted command yields its result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("no result after accepted command");

    // no result without a command
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result without command");

    // only a successful pop carries an item
    a_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (item_out == '0))
        else $error("item on failed operation");

    // empty and shut-down answers on a pop imply nothing is held
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(func) == FN_POP && (status == ST_EMPTY || status == ST_SHUT))
        |-> (fill_level == '0))
        else $error("empty answer with items held");

    // a push of a zero item never succeeds
    a_null_push: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item_in == '0 &&
         (func == FN_PUSH_TAIL || func == FN_PUSH_HEAD)) |=> (status != ST_OK))
        else $error("null item accepted");

endmodule

bind ring_deque_work_queue_top rdq_checker #(.ITEM_WIDTH(ITEM_WIDTH)) u_rdq_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .item_in    (item_in),
    .done       (done),
    .status     (status),
    .item_out   (item_out),
    .fill_level (fill_level)
);

@@ test/ring_deque_work_queue_top_tb.sv @@
// Self-checking testbench for the ring deque work queue: command driver, result monitor, queue predictor.
`timescale 1ns / 100ps

module ring_deque_work_queue_top_tb;

    import rdq_pkg::*;

    localparam int SLOT_COUNT = DEPTH_DEF;
    localparam int STALL_LIMIT = 1000;   // cycles without any transfer before giving up

    // One queued command for the driver, with the idle cycles to insert ahead of it.
    typedef struct {
        logic [FUNC_W-1:0]         op;
        logic [ITEM_WIDTH_DEF-1:0] word;
        int                        gap;
    } cmd_t;

    // What the queue should answer for one command.
    typedef struct {
        status_t                   code;
        logic [ITEM_WIDTH_DEF-1:0] word;
        logic [FILL_W-1:0]         level;
    } reply_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [FUNC_W-1:0]         func = '0;
    logic [ITEM_WIDTH_DEF-1:0] item_in = '0;
    logic                      done;
    status_t                   status;
    logic [ITEM_WIDTH_DEF-1:0] item_out;
    logic [FILL_W-1:0]         fill_level;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CAP_W-1:0]          cfg_data = '0;

    ring_deque_work_queue_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .item_in    (item_in),
        .done       (done),
        .status     (status),
        .item_out   (item_out),
        .fill_level (fill_level),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the ring, its pointers and the
    // capacity register. Updated only on observed transfers.
    // ------------------------------------------------------------------
    logic [ITEM_WIDTH_DEF-1:0] ring_slots [SLOT_COUNT];
    int                        head_ptr = 0;
    int                        tail_ptr = 0;
    int                        held = 0;
    bit                        shut_down = 1'b0;
    logic [CAP_W-1:0]          cap_reg = CAP_RESET;

    cmd_t   cmd_backlog [$];   // commands still to be sent
    reply_t replies_due [$];   // answers owed by the queue, oldest first

    bit cmd_fire = 1'b0;       // command transfer seen at the last rising edge
    int gap_count = 0;
    int idle_cycles = 0;
    int n_cmds = 0;
    int n_results = 0;
    int n_cfg = 0;
    int n_errors = 0;
    int status_hits [5] = '{default: 0};

    // Apply one operation to the shadow queue and return the answer it owes.
    function automatic reply_t apply_queue_op(input logic [FUNC_W-1:0] op,
                                              input logic [ITEM_WIDTH_DEF-1:0] word);
        reply_t r;
        int     cap;
        r.code = ST_OK;
        r.word = '0;
        // out-of-range capacity clamps to 1..DEPTH
        cap = int'(cap_reg);
        if (cap == 0)
            cap = 1;
        if (cap > SLOT_COUNT)
            cap = SLOT_COUNT;
        case (op)
            FN_PUSH_TAIL, FN_PUSH_HEAD:
            begin
                // shutdown wins over full, full wins over a null item
                if (shut_down)
                    r.code = ST_SHUT;
                else if (held >= cap)
                    r.code = ST_FULL;
                else if (word == '0)
                    r.code = ST_NULL;
                else if (op == FN_PUSH_TAIL)
                begin
                    ring_slots[tail_ptr % SLOT_COUNT] = word;
                    tail_ptr = (tail_ptr + 1 >= cap) ? 0 : tail_ptr + 1;
                    held++;
                end
                else
                begin
                    head_ptr = (head_ptr == 0 || head_ptr > cap) ? cap - 1 : head_ptr - 1;
                    ring_slots[head_ptr % SLOT_COUNT] = word;
                    held++;
                end
            end
            FN_POP:
            begin
                if (held == 0)
                    r.code = shut_down ? ST_SHUT : ST_EMPTY;
                else
                begin
                    r.word = ring_slots[head_ptr % SLOT_COUNT];
                    head_ptr = (head_ptr + 1 >= cap) ? 0 : head_ptr + 1;
                    held--;
                end
            end
            FN_CLEAR:
            begin
                // flag survives a clear
                head_ptr = 0;
                tail_ptr = 0;
                held = 0;
            end
            FN_SHUTDOWN:
                shut_down = 1'b1;
            default: ;   // codes 5..7 do nothing
        endcase
        r.level = held[FILL_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents commands at the falling edge, inserting the idle
    // gap each command carries. start stays high across back-to-back
    // transfers.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        cmd_t cur;
        if (start && !cmd_fire)
            ;   // not taken yet, hold the command
        else if (cmd_backlog.size() == 0)
            start <= 1'b0;
        else if (gap_count < cmd_backlog[0].gap)
        begin
            start <= 1'b0;
            gap_count++;
        end
        else
        begin
            cur = cmd_backlog.pop_front();
            start <= 1'b1;
            func <= cur.op;
            item_in <= cur.word;
            gap_count = 0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every command transfer, tracks capacity
    // writes, checks every done strobe against the oldest answer owed.
    // Also runs the stall watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            cmd_fire <= start && !busy;
            if (start && !busy)
            begin
                replies_due.push_back(apply_queue_op(func, item_in));
                n_cmds++;
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_reg = cfg_data;
                n_cfg++;
            end
            if (done)
            begin
                n_results++;
                if (replies_due.size() == 0)
                begin
                    $error("result with nothing owed: status %0d item_out %h fill_level %0d",
                           status, item_out, fill_level);
                    n_errors++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    status_hits[want.code]++;
                    if (status !== want.code)
                    begin
                        $error("status: expected %0d, got %0d", want.code, status);
                        n_errors++;
                    end
                    if (item_out !== want.word)
                    begin
                        $error("item_out: expected %h, got %h", want.word, item_out);
                        n_errors++;
                    end
                    if (fill_level !== want.level)
                    begin
                        $error("fill_level: expected %0d, got %0d", want.level, fill_level);
                        n_errors++;
                    end
                end
            end
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_cmd(input logic [FUNC_W-1:0] op, input logic [ITEM_WIDTH_DEF-1:0] word,
                           input int gap);
        cmd_t c;
        c.op = op;
        c.word = word;
        c.gap = gap;
        cmd_backlog.push_back(c);
    endtask

    // Wait until every command went out and every answer came back,
    // then let the clock run on so nothing is in flight.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (cmd_backlog.size() != 0 || start || replies_due.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    // Capacity write, only ever done with the queue idle.
    task automatic set_capacity(input logic [CAP_W-1:0] val);
        wait_idle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ITEM_WIDTH_DEF-1:0] pick_word();
        int r;
        r = $urandom_range(0, 39);
        if (r == 0)
            return '0;              // null item
        if (r == 1)
            return '1;
        if (r == 2)
            return 32'h1 << $urandom_range(0, 31);
        return $urandom();
    endfunction

    // Mixed traffic: push_pct biases toward filling or draining.
    // A bursty stretch runs with no gaps at all.
    task automatic add_mix(input int n_items, input int push_pct);
        int r;
        int gap;
        bit burst;
        logic [FUNC_W-1:0] op;
        burst = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                op = ($urandom_range(0, 2) == 0) ? FN_PUSH_HEAD : FN_PUSH_TAIL;
            else if (r < 96)
                op = FN_POP;
            else if (r < 98)
                op = FN_CLEAR;
            else
                op = FUNC_W'($urandom_range(5, 7));   // unused codes
            gap = burst ? 0 : $urandom_range(0, 4);
            add_cmd(op, pick_word(), gap);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [CAP_W-1:0] cap_plan [12];
        cap_plan = '{5'd16, 5'd1, 5'd0, 5'd2, 5'd31, 5'd17, 5'd8, 5'd3, 5'd15, 5'd0, 5'd16, 5'd5};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset capacity of 16: empty pop, null push, word extremes,
        // head-push ordering, unused codes, clear on empty.
        add_cmd(FN_POP, '0, 0);
        add_cmd(FN_PUSH_TAIL, '0, 1);
        add_cmd(FN_PUSH_TAIL, 32'hFFFF_FFFF, 0);
        add_cmd(FN_PUSH_TAIL, 32'h0000_0001, 2);
        add_cmd(FN_PUSH_HEAD, 32'h8000_0000, 0);
        add_cmd(FN_POP, '0, 0);
        add_cmd(FN_POP, '0, 4);
        add_cmd(FN_POP, '0, 0);
        add_cmd(3'd5, 32'h1234_5678, 0);
        add_cmd(3'd6, '0, 1);
        add_cmd(3'd7, '1, 0);
        add_cmd(FN_CLEAR, '0, 0);

        // Directed, capacity one: full on both ends, full beats null.
        set_capacity(5'd1);
        add_cmd(FN_CLEAR, '0, 0);
        add_cmd(FN_PUSH_TAIL, 32'hA5A5_5A5A, 0);
        add_cmd(FN_PUSH_TAIL, 32'h5A5A_A5A5, 0);
        add_cmd(FN_PUSH_HEAD, 32'h0F0F_0F0F, 3);
        add_cmd(FN_PUSH_TAIL, '0, 0);
        add_cmd(FN_POP, '0, 0);
        add_cmd(FN_PUSH_HEAD, 32'hDEAD_BEEF, 0);
        add_cmd(FN_POP, '0, 0);
        add_cmd(FN_POP, '0, 0);

        // Random phases over a spread of capacities, out-of-range ones included.
        // Clear first so pointers start from zero under the new capacity.
        foreach (cap_plan[k])
        begin
            set_capacity(k < 10 ? cap_plan[k] : CAP_W'($urandom_range(0, 31)));
            add_cmd(FN_CLEAR, '0, $urandom_range(0, 4));
            add_mix(40, 70);
            add_mix(35, 30);
        end

        // Shutdown comes last: the flag only leaves with a reset.
        set_capacity(5'd4);
        add_cmd(FN_CLEAR, '0, 0);
        add_cmd(FN_PUSH_TAIL, 32'h0000_0011, 0);
        add_cmd(FN_PUSH_HEAD, 32'h0000_0022, 1);
        add_cmd(FN_PUSH_TAIL, 32'h0000_0033, 0);
        add_cmd(FN_PUSH_TAIL, 32'h0000_0044, 0);
        add_cmd(FN_SHUTDOWN, '0, 2);
        add_cmd(FN_PUSH_TAIL, 32'h0000_0055, 0);   // full and shut: shut wins
        add_cmd(FN_PUSH_HEAD, '0, 0);              // null and shut: shut wins
        add_cmd(FN_POP, '0, 0);
        add_cmd(FN_POP, '0, 3);
        add_cmd(FN_SHUTDOWN, '0, 0);               // second shutdown is harmless
        add_cmd(FN_POP, '0, 0);
        add_cmd(FN_POP, '0, 0);
        add_cmd(FN_POP, '0, 0);                    // drained and shut
        add_cmd(FN_CLEAR, '0, 1);
        add_cmd(FN_POP, '0, 0);
        add_cmd(FN_PUSH_TAIL, 32'h0000_0066, 0);
        add_mix(40, 50);

        wait_idle();
        $display("Covered %0d command transfers, %0d results, %0d capacity writes",
                 n_cmds, n_results, n_cfg);
        $display("Answers seen: ok %0d, full %0d, empty %0d, shut %0d, null %0d",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_SHUT], status_hits[ST_NULL]);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ ring_deque_work_queue_top.f @@
rtl/rdq_pkg.sv
rtl/rdq_ram.sv
rtl/ring_deque_work_queue_top.sv
rtl/rdq_checker.sv
test/ring_deque_work_queue_top_tb.sv
